>>> src/usms_pkg.sv
// ----------------------------------------------------------------------------
// usms_pkg: shared types and constants for the URL secret marker scanner
// Payload structs, the marker table, window type and byte helpers.
// ----------------------------------------------------------------------------
package usms_pkg;

	localparam int MARKER_COUNT   = 6;
	localparam int MAX_MARKER_LEN = 8;
	localparam int WIN_DEPTH      = MAX_MARKER_LEN - 1;
	localparam int LEN_W          = $clog2(MAX_MARKER_LEN + 1);

	typedef logic [7:0] byte_t;
	typedef byte_t [WIN_DEPTH-1:0] window_t;

	typedef struct packed {
		logic [7:0] url_byte;
		logic       end_of_url;
	} in_item_t;

	typedef struct packed {
		logic secret_found;
		logic found_raw;
		logic found_decoded;
	} out_item_t;

	typedef struct packed {
		logic       ok;
		logic [3:0] val;
	} hex_t;

	typedef struct packed {
		logic    hit;
		window_t win;
	} feed_t;

	localparam byte_t CHAR_PCT   = 8'h25;
	localparam byte_t CHAR_PLUS  = 8'h2B;
	localparam byte_t CHAR_SPACE = 8'h20;
	localparam byte_t CHAR_NUL   = 8'h00;

	localparam logic [LEN_W-1:0] MARKER_LEN [MARKER_COUNT] = '{
		LEN_W'(7), LEN_W'(6), LEN_W'(8), LEN_W'(8), LEN_W'(4), LEN_W'(4)
	};

	// lowercase text, unused tail bytes zero
	localparam byte_t MARKER_TEXT [MARKER_COUNT][MAX_MARKER_LEN] = '{
		'{"s", "k", "-", "a", "n", "t", "-", CHAR_NUL},
		'{"s", "k", "-", "o", "r", "-", CHAR_NUL, CHAR_NUL},
		'{"s", "k", "-", "p", "r", "o", "j", "-"},
		'{"s", "k", "_", "l", "i", "v", "e", "_"},
		'{"a", "k", "i", "a", CHAR_NUL, CHAR_NUL, CHAR_NUL, CHAR_NUL},
		'{"g", "h", "p", "_", CHAR_NUL, CHAR_NUL, CHAR_NUL, CHAR_NUL}
	};

	function automatic byte_t fold_case(byte_t c);
		if (c >= "A" && c <= "Z") begin
			return c + 8'h20;
		end
		return c;
	endfunction

	function automatic hex_t hex_digit(byte_t c);
		hex_t h;
		h.ok  = 1'b1;
		h.val = 4'h0;
		if (c >= "0" && c <= "9") begin
			h.val = 4'(c - "0");
		end else if (c >= "a" && c <= "f") begin
			h.val = 4'(c - "a" + 8'd10);
		end else if (c >= "A" && c <= "F") begin
			h.val = 4'(c - "A" + 8'd10);
		end else begin
			h.ok = 1'b0;
		end
		return h;
	endfunction

	// c is the folded newest byte; win holds the previous bytes, newest at top
	function automatic logic marker_hit(window_t win, byte_t c);
		logic  hit;
		logic  ok;
		byte_t have;
		int    back;
		hit = 1'b0;
		for (int m = 0; m < MARKER_COUNT; m++) begin
			ok = 1'b1;
			for (int j = 0; j < MAX_MARKER_LEN; j++) begin
				if (j < int'(MARKER_LEN[m])) begin
					back = int'(MARKER_LEN[m]) - 1 - j;
					have = c;
					for (int k = 0; k < WIN_DEPTH; k++) begin
						if (back != 0 && k == WIN_DEPTH - back) begin
							have = win[k];
						end
					end
					if (have != MARKER_TEXT[m][j]) begin
						ok = 1'b0;
					end
				end
			end
			hit = hit | ok;
		end
		return hit;
	endfunction

	function automatic feed_t feed(window_t win, byte_t b);
		feed_t f;
		byte_t c;
		c     = fold_case(b);
		f.hit = marker_hit(win, c);
		f.win = {c, win[WIN_DEPTH-1:1]};
		return f;
	endfunction

endpackage

>>> src/url_secret_marker_scan.sv
// ----------------------------------------------------------------------------
// url_secret_marker_scan: case-insensitive key-prefix scan of a URL stream
// Raw and percent-decoded channels, one result per URL on its final byte.
// ----------------------------------------------------------------------------
// Throughput: one URL byte per clock; a final byte stalls while the result register
//   still holds a result that has not been taken.
// Path: a final byte's result passes the input register, then the result register.
// Reset: arst_n clears windows, escape state, hit flags and both valid flags;
//   after each final byte the scan state returns to its reset values.
module url_secret_marker_scan (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  usms_pkg::in_item_t   in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output usms_pkg::out_item_t  out_data
);
	import usms_pkg::*;

	typedef enum logic [1:0] {
		ESC_IDLE = 2'd0,
		ESC_PCT  = 2'd1,
		ESC_HEX  = 2'd2
	} esc_phase_t;

	logic       in_valid_s1;
	in_item_t   in_s1;
	out_item_t  res_s2;
	logic       res_valid_s2;

	window_t    raw_win_q;
	window_t    dec_win_q;
	esc_phase_t esc_phase_q;
	byte_t      esc_hi_q;
	logic       raw_hit_q;
	logic       dec_hit_q;

	logic       adv;
	feed_t      raw_f;
	feed_t      dec_f0, dec_f1, dec_f2;
	byte_t      emit0, emit1, emit2;
	logic [1:0] emit_n;
	esc_phase_t esc_phase_d;
	logic       esc_hi_load;
	window_t    dec_win_d;
	logic       raw_hit_d;
	logic       dec_hit_d;
	logic       plain_opens;
	byte_t      plain_byte;
	hex_t       hex_b;
	hex_t       hex_hi;

	// a final byte needs the result register free; others always move on
	assign adv      = in_valid_s1 && (!in_s1.end_of_url || !res_valid_s2 || out_ready);
	assign in_ready = !in_valid_s1 || adv;

	assign out_valid = res_valid_s2;
	assign out_data  = res_s2;

	always_comb begin
		hex_b  = hex_digit(in_s1.url_byte);
		hex_hi = hex_digit(esc_hi_q);
		raw_f  = feed(raw_win_q, in_s1.url_byte);

		// plain decode of the current byte
		plain_opens = (in_s1.url_byte == CHAR_PCT) && !in_s1.end_of_url;
		plain_byte  = (in_s1.url_byte == CHAR_PLUS) ? CHAR_SPACE : in_s1.url_byte;

		emit0       = CHAR_PCT;
		emit1       = esc_hi_q;
		emit2       = plain_byte;
		emit_n      = 2'd0;
		esc_phase_d = ESC_IDLE;
		esc_hi_load = 1'b0;

		case (esc_phase_q)
			ESC_PCT: begin
				if (hex_b.ok && !in_s1.end_of_url) begin
					esc_hi_load = 1'b1;
					esc_phase_d = ESC_HEX;
				end else begin
					emit1 = plain_byte;
					if (plain_opens) begin
						esc_phase_d = ESC_PCT;
						emit_n      = 2'd1;
					end else begin
						emit_n = 2'd2;
					end
				end
			end
			ESC_HEX: begin
				if (hex_b.ok && hex_hi.ok) begin
					emit0  = {hex_hi.val, hex_b.val};
					emit_n = 2'd1;
				end else if (plain_opens) begin
					esc_phase_d = ESC_PCT;
					emit_n      = 2'd2;
				end else begin
					emit_n = 2'd3;
				end
			end
			default: begin
				emit0 = plain_byte;
				if (plain_opens) begin
					esc_phase_d = ESC_PCT;
				end else begin
					emit_n = 2'd1;
				end
			end
		endcase

		// up to three decoded bytes go through the window in order
		dec_f0    = feed(dec_win_q, emit0);
		dec_f1    = feed(dec_f0.win, emit1);
		dec_f2    = feed(dec_f1.win, emit2);
		dec_win_d = dec_win_q;
		dec_hit_d = dec_hit_q;
		case (emit_n)
			2'd1: begin
				dec_win_d = dec_f0.win;
				dec_hit_d = dec_hit_q | dec_f0.hit;
			end
			2'd2: begin
				dec_win_d = dec_f1.win;
				dec_hit_d = dec_hit_q | dec_f0.hit | dec_f1.hit;
			end
			2'd3: begin
				dec_win_d = dec_f2.win;
				dec_hit_d = dec_hit_q | dec_f0.hit | dec_f1.hit | dec_f2.hit;
			end
			default: begin
			end
		endcase
		raw_hit_d = raw_hit_q | raw_f.hit;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1  <= 1'b0;
			in_s1        <= '0;
			res_valid_s2 <= 1'b0;
			res_s2       <= '0;
			raw_win_q    <= '0;
			dec_win_q    <= '0;
			esc_phase_q  <= ESC_IDLE;
			esc_hi_q     <= '0;
			raw_hit_q    <= 1'b0;
			dec_hit_q    <= 1'b0;
		end else begin
			if (in_ready) begin
				in_valid_s1 <= in_valid;
				in_s1       <= in_data;
			end
			if (out_ready) begin
				res_valid_s2 <= 1'b0;
			end
			if (adv) begin
				if (in_s1.end_of_url) begin
					res_valid_s2         <= 1'b1;
					res_s2.secret_found  <= raw_hit_d | dec_hit_d;
					res_s2.found_raw     <= raw_hit_d;
					res_s2.found_decoded <= dec_hit_d;
					raw_win_q            <= '0;
					dec_win_q            <= '0;
					esc_phase_q          <= ESC_IDLE;
					esc_hi_q             <= '0;
					raw_hit_q            <= 1'b0;
					dec_hit_q            <= 1'b0;
				end else begin
					raw_win_q   <= raw_f.win;
					dec_win_q   <= dec_win_d;
					esc_phase_q <= esc_phase_d;
					raw_hit_q   <= raw_hit_d;
					dec_hit_q   <= dec_hit_d;
					if (esc_hi_load) begin
						esc_hi_q <= in_s1.url_byte;
					end
				end
			end
		end
	end

`ifndef SYNTHESIS
	// a waiting result is never overwritten by the next URL's result
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_s2 && !out_ready) |-> !(adv && in_s1.end_of_url))
		else $error("result register overwritten while stalled");

	// the scan state is back at reset after a final byte
	a_url_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && in_s1.end_of_url) |=> (esc_phase_q == ESC_IDLE && !raw_hit_q && !dec_hit_q))
		else $error("scan state not cleared after final byte");

	a_summary_flag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.secret_found == (out_data.found_raw | out_data.found_decoded)))
		else $error("secret_found disagrees with channel flags");
`endif

endmodule

>>> dv/tb_url_secret_marker_scan.sv
// ----------------------------------------------------------------------------
// tb_url_secret_marker_scan: self-checking bench for the URL marker scanner
// A short table of hand-picked URLs, then random URLs built from markers,
// escapes and noise. Accepted bytes pass a local model of both scan channels;
// URL verdicts are checked field by field against it or a typed-in verdict.
// ----------------------------------------------------------------------------
module tb_url_secret_marker_scan;

	import usms_pkg::in_item_t;
	import usms_pkg::out_item_t;

	typedef enum logic [1:0] {ESC_IDLE, ESC_PCT, ESC_HI} esc_e;

	typedef struct packed {
		logic [7:0] ch;
		logic       last;
		logic       typed;
		out_item_t  want;
	} dir_row_t;

	localparam int         RANDOM_BYTES = 1650;
	localparam logic [7:0] PCT          = "%";
	localparam logic [7:0] PLUS         = "+";
	localparam logic [7:0] SPACE        = " ";

	// markers right-justified, first character in the highest used byte
	localparam logic [63:0] MARK_TEXT [6] = '{
		"sk-ant-", "sk-or-", "sk-proj-", {"sk_l", "ive_"}, "akia", "ghp_"
	};
	localparam int MARK_LEN [6] = '{7, 6, 8, 8, 4, 4};

	logic      clk;
	logic      arst_n;
	logic      in_valid;
	logic      in_ready;
	in_item_t  in_data;
	logic      out_valid;
	logic      out_ready;
	out_item_t out_data;

	// typed-in verdict travelling alongside the current byte
	logic      row_typed;
	out_item_t row_want;

	logic [55:0] raw_tail;
	logic [55:0] dec_tail;
	esc_e        esc_state;
	logic [7:0]  esc_first;
	logic        raw_seen;
	logic        dec_seen;

	out_item_t   verdict_q [$];
	logic [7:0]  url_q [$];

	int  errors;
	int  bytes_in;
	int  urls_done;
	int  urls_raw;
	int  urls_dec_only;
	int  sent;
	bit  no_gaps;
	bit  hold_req;

	string ESC_SET = "0123456789abcdefABCDEFg%+z";
	string URL_SET = "abcdefghijklmnopqrstuvwxyz0123456789/:?=&.-_";

	dir_row_t dir_rows [26] = '{
		'{"A", 1'b0, 1'b0, 3'b000},
		'{"K", 1'b0, 1'b0, 3'b000},
		'{"I", 1'b0, 1'b0, 3'b000},
		'{"A", 1'b1, 1'b1, 3'b111},
		'{8'h00, 1'b1, 1'b1, 3'b000},
		'{8'hFF, 1'b1, 1'b1, 3'b000},
		// escaped 'G' then "hp_": decoded channel only
		'{"%", 1'b0, 1'b0, 3'b000},
		'{"4", 1'b0, 1'b0, 3'b000},
		'{"7", 1'b0, 1'b0, 3'b000},
		'{"H", 1'b0, 1'b0, 3'b000},
		'{"p", 1'b0, 1'b0, 3'b000},
		'{"_", 1'b1, 1'b1, 3'b101},
		'{"+", 1'b0, 1'b0, 3'b000},
		'{"%", 1'b1, 1'b0, 3'b000},
		'{"%", 1'b0, 1'b0, 3'b000},
		'{"z", 1'b1, 1'b0, 3'b000},
		'{"%", 1'b0, 1'b0, 3'b000},
		'{"4", 1'b0, 1'b0, 3'b000},
		'{"G", 1'b1, 1'b0, 3'b000},
		'{"%", 1'b0, 1'b0, 3'b000},
		'{"2", 1'b1, 1'b0, 3'b000},
		// decoded '%' must not open a second escape
		'{"%", 1'b0, 1'b0, 3'b000},
		'{"2", 1'b0, 1'b0, 3'b000},
		'{"5", 1'b0, 1'b0, 3'b000},
		'{"4", 1'b0, 1'b0, 3'b000},
		'{"1", 1'b1, 1'b0, 3'b000}
	};

	url_secret_marker_scan dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	initial clk = 1'b0;
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// ---- scan model ----

	function automatic logic [7:0] lower(logic [7:0] c);
		return (c >= "A" && c <= "Z") ? c + 8'h20 : c;
	endfunction

	function automatic logic is_hex(logic [7:0] c);
		return (c >= "0" && c <= "9") || (lower(c) >= "a" && lower(c) <= "f");
	endfunction

	function automatic logic [3:0] nibble(logic [7:0] c);
		if (c <= "9") begin
			return 4'(c - "0");
		end
		return 4'(lower(c) - "a" + 8'd10);
	endfunction

	// does a marker end at folded byte c, given the seven bytes before it
	function automatic logic tail_hit(logic [55:0] tail, logic [7:0] c);
		logic [63:0] hist;
		logic        ok;
		logic        hit;
		hist = {tail, c};
		hit  = 1'b0;
		for (int m = 0; m < 6; m++) begin
			ok = 1'b1;
			for (int j = 0; j < MARK_LEN[m]; j++) begin
				if (hist[8*j +: 8] != MARK_TEXT[m][8*j +: 8]) begin
					ok = 1'b0;
				end
			end
			hit |= ok;
		end
		return hit;
	endfunction

	function automatic void feed(logic dec_chan, logic [7:0] b);
		logic [7:0] c;
		c = lower(b);
		if (dec_chan) begin
			if (tail_hit(dec_tail, c)) begin
				dec_seen = 1'b1;
			end
			dec_tail = {dec_tail[47:0], c};
		end else begin
			if (tail_hit(raw_tail, c)) begin
				raw_seen = 1'b1;
			end
			raw_tail = {raw_tail[47:0], c};
		end
	endfunction

	function automatic void plain(logic [7:0] b, logic last);
		if (b == PCT && !last) begin
			esc_state = ESC_PCT;
		end else if (b == PLUS) begin
			feed(1'b1, SPACE);
		end else begin
			feed(1'b1, b);
		end
	endfunction

	function automatic void clear_scan();
		raw_tail  = '0;
		dec_tail  = '0;
		esc_state = ESC_IDLE;
		esc_first = '0;
		raw_seen  = 1'b0;
		dec_seen  = 1'b0;
	endfunction

	// returns 1 when the byte closes a URL, with its verdict in res
	function automatic logic scan_byte(in_item_t it, output out_item_t res);
		logic [7:0] b;
		logic       last;
		b    = it.url_byte;
		last = it.end_of_url;
		res  = '0;
		feed(1'b0, b);
		case (esc_state)
		ESC_PCT: begin
			if (is_hex(b) && !last) begin
				esc_first = b;
				esc_state = ESC_HI;
			end else begin
				esc_state = ESC_IDLE;
				feed(1'b1, PCT);
				plain(b, last);
			end
		end
		ESC_HI: begin
			esc_state = ESC_IDLE;
			if (is_hex(esc_first) && is_hex(b)) begin
				feed(1'b1, {nibble(esc_first), nibble(b)});
			end else begin
				feed(1'b1, PCT);
				feed(1'b1, esc_first);
				plain(b, last);
			end
		end
		default: begin
			esc_state = ESC_IDLE;
			plain(b, last);
		end
		endcase
		if (!last) begin
			return 1'b0;
		end
		res.secret_found  = raw_seen | dec_seen;
		res.found_raw     = raw_seen;
		res.found_decoded = dec_seen;
		clear_scan();
		return 1'b1;
	endfunction

	// ---- URL generation ----

	function automatic logic [7:0] hex_char(logic [3:0] nib);
		if (nib < 4'd10) begin
			return "0" + 8'(nib);
		end
		return ($urandom_range(0, 1) ? "a" : "A") + 8'(nib) - 8'd10;
	endfunction

	function automatic void push_escaped(logic [7:0] ch);
		url_q.insert(url_q.size(), PCT);
		url_q.insert(url_q.size(), hex_char(ch[7:4]));
		url_q.insert(url_q.size(), hex_char(ch[3:0]));
	endfunction

	function automatic void compose_url();
		int         m;
		int         len;
		int         n;
		logic [7:0] ch;
		url_q.delete();
		repeat ($urandom_range(1, 5)) begin
			m   = $urandom_range(0, 5);
			len = MARK_LEN[m];
			case ($urandom_range(0, 9))
			0, 1, 2, 3: begin
				// whole marker, or a cut-down one for near misses
				n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, len - 1) : len;
				for (int j = 0; j < n; j++) begin
					ch = MARK_TEXT[m][8*(len-1-j) +: 8];
					if (ch >= "a" && ch <= "z" && $urandom_range(0, 1)) begin
						ch = ch - 8'h20;
					end
					if ($urandom_range(0, 3) == 0) begin
						push_escaped(ch);
					end else begin
						url_q.insert(url_q.size(), ch);
					end
				end
			end
			4: begin
				url_q.insert(url_q.size(), PCT);
				repeat ($urandom_range(0, 2)) begin
					url_q.insert(url_q.size(),
						ESC_SET[$urandom_range(0, ESC_SET.len() - 1)]);
				end
			end
			5: begin
				if ($urandom_range(0, 1)) begin
					url_q.insert(url_q.size(), PLUS);
				end else begin
					push_escaped(PLUS);
				end
			end
			6: begin
				repeat ($urandom_range(1, 3)) begin
					url_q.insert(url_q.size(), 8'($urandom_range(0, 255)));
				end
			end
			default: begin
				repeat ($urandom_range(1, 4)) begin
					url_q.insert(url_q.size(),
						URL_SET[$urandom_range(0, URL_SET.len() - 1)]);
				end
			end
			endcase
		end
	endfunction

	// ---- driving ----

	task automatic send_byte(logic [7:0] b, logic last, logic typed, out_item_t want);
		while (!no_gaps && $urandom_range(0, 99) < 32) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid  <= 1'b1;
		in_data   <= in_item_t'{url_byte: b, end_of_url: last};
		row_typed <= typed;
		row_want  <= want;
		@(posedge clk);
		while (!in_ready) begin
			@(posedge clk);
		end
		@(negedge clk);
		sent++;
	endtask

	task automatic flag_error(string msg);
		$display("ERROR t=%0t: %s", $time, msg);
		errors++;
	endtask

	initial begin
		bit hold_done;
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		in_data   = '0;
		row_typed = 1'b0;
		row_want  = '0;
		no_gaps   = 1'b0;
		hold_req  = 1'b0;
		hold_done = 1'b0;
		errors    = 0;
		sent      = 0;
		clear_scan();
		repeat (11) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (dir_rows[i]) begin
			send_byte(dir_rows[i].ch, dir_rows[i].last, dir_rows[i].typed, dir_rows[i].want);
		end

		while (sent < RANDOM_BYTES) begin
			// a stretch running flat out on both sides
			no_gaps = (sent >= 700 && sent < 1000);
			if (!hold_done && sent >= 300) begin
				hold_req  = 1'b1;
				hold_done = 1'b1;
			end
			compose_url();
			foreach (url_q[i]) begin
				send_byte(url_q[i], i == url_q.size() - 1, 1'b0, '0);
			end
		end
		in_valid <= 1'b0;
		no_gaps   = 1'b0;

		while (verdict_q.size() != 0) begin
			@(posedge clk);
		end
		repeat (10) @(posedge clk);

		$display("Scanned %0d bytes forming %0d URLs.", bytes_in, urls_done);
		$display("Flagged: %0d with a raw marker, %0d through decoding alone.",
			urls_raw, urls_dec_only);
		if (errors == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

	// receiver: random back-pressure plus one long hold-off
	initial begin
		int hold_left;
		hold_left = 0;
		out_ready = 1'b0;
		wait (arst_n);
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req  = 1'b0;
				hold_left = 240;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= no_gaps || ($urandom_range(0, 99) >= 32);
			end
		end
	end

	// ---- checking ----

	always @(posedge clk) begin : watch
		out_item_t pred;
		out_item_t want;
		if (arst_n) begin
			if (in_valid && in_ready) begin
				bytes_in++;
				if (scan_byte(in_data, pred)) begin
					verdict_q.insert(verdict_q.size(), row_typed ? row_want : pred);
				end
			end
			if (out_valid && out_ready) begin
				if (verdict_q.size() == 0) begin
					flag_error($sformatf("result %b with no URL outstanding", out_data));
				end else begin
					want = verdict_q.pop_front();
					urls_done++;
					if (want.found_raw) begin
						urls_raw++;
					end else if (want.found_decoded) begin
						urls_dec_only++;
					end
					if (out_data.secret_found !== want.secret_found) begin
						flag_error($sformatf("URL %0d secret_found %b, want %b",
							urls_done, out_data.secret_found, want.secret_found));
					end
					if (out_data.found_raw !== want.found_raw) begin
						flag_error($sformatf("URL %0d found_raw %b, want %b",
							urls_done, out_data.found_raw, want.found_raw));
					end
					if (out_data.found_decoded !== want.found_decoded) begin
						flag_error($sformatf("URL %0d found_decoded %b, want %b",
							urls_done, out_data.found_decoded, want.found_decoded));
					end
				end
			end
		end
	end

	initial begin
		#400000;
		$display("Timed out with %0d URL verdicts outstanding.", verdict_q.size());
		$display("FAILURE");
		$finish;
	end

endmodule
